// ===== sv/pfcu_pkg.sv =====
// Package: shared types, codes and Pauli letter update functions.
`timescale 1ns / 1ps

package pfcu_pkg;

    localparam int unsigned QUBIT_W        = 6;
    localparam int unsigned LTR_W          = 2;
    localparam int unsigned TURNS_W        = 2;
    localparam int unsigned DEF_NUM_QUBITS = 64;

    // Letter code: bit 0 is the X part, bit 1 the Z part.
    localparam logic [LTR_W-1:0] LTR_I = 2'd0;
    localparam logic [LTR_W-1:0] LTR_X = 2'd1;
    localparam logic [LTR_W-1:0] LTR_Z = 2'd2;
    localparam logic [LTR_W-1:0] LTR_Y = 2'd3;

    typedef enum logic [1:0] {
        ACT_GATE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_SIGN  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        GATE_H  = 2'd0,
        GATE_CX = 2'd1,
        GATE_RZ = 2'd2,
        GATE_RX = 2'd3
    } t_gate;

    typedef struct packed {
        logic [LTR_W-1:0] letter;
        logic             neg;
    } t_pauli;

    // Decoded item held in the compute stage.
    typedef struct packed {
        t_action            action;
        t_gate              kind;
        logic [TURNS_W-1:0] turns;
        logic [LTR_W-1:0]   letter_in;
        logic               sign_in;
        logic               ok1;
        logic               ok2;
        logic               same_q;
    } t_cmd;

    // Update produced by the compute stage.
    typedef struct packed {
        logic [LTR_W-1:0] new1;
        logic [LTR_W-1:0] new2;
        logic             we1;
        logic             we2;
        logic             sign;
        logic [LTR_W-1:0] res_letter;
    } t_upd;

    // Hadamard: swap X and Z parts, Y picks up a minus sign.
    function automatic t_pauli f_had(input logic [LTR_W-1:0] l);
        t_pauli res;
        res.letter = {l[0], l[1]};
        res.neg    = (l == LTR_Y);
        return res;
    endfunction

    // S gate: X -> Y, Y -> -X.
    function automatic t_pauli f_s(input logic [LTR_W-1:0] l);
        t_pauli res;
        res.letter = {l[1] ^ l[0], l[0]};
        res.neg    = (l == LTR_Y);
        return res;
    endfunction

    // Z rotation: S applied turns times.
    function automatic t_pauli f_zrot(input logic [LTR_W-1:0] l,
                                      input logic [TURNS_W-1:0] turns);
        t_pauli acc;
        t_pauli step;
        acc.letter = l;
        acc.neg    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (TURNS_W'(i) < turns) begin
                step       = f_s(acc.letter);
                acc.letter = step.letter;
                acc.neg    = acc.neg ^ step.neg;
            end
        end
        return acc;
    endfunction

    // X rotation: Z rotation between two Hadamards.
    function automatic t_pauli f_xrot(input logic [LTR_W-1:0] l,
                                      input logic [TURNS_W-1:0] turns);
        t_pauli h1;
        t_pauli z;
        t_pauli h2;
        t_pauli res;
        h1         = f_had(l);
        z          = f_zrot(h1.letter, turns);
        h2         = f_had(z.letter);
        res.letter = h2.letter;
        res.neg    = h1.neg ^ z.neg ^ h2.neg;
        return res;
    endfunction

endpackage

// ===== sv/pfcu_bank.sv =====
// Letter bank: one write port, two registered read ports.
`timescale 1ns / 1ps

module pfcu_bank #(
    parameter int unsigned DEPTH = pfcu_pkg::DEF_NUM_QUBITS
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr1,
    output logic [pfcu_pkg::LTR_W-1:0]   o_rd_data0,
    output logic [pfcu_pkg::LTR_W-1:0]   o_rd_data1,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [pfcu_pkg::LTR_W-1:0]   i_wr_data
);

    logic [pfcu_pkg::LTR_W-1:0] mem [DEPTH];
    logic [pfcu_pkg::LTR_W-1:0] r_rd_data0;
    logic [pfcu_pkg::LTR_W-1:0] r_rd_data1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data0 <= mem[i_rd_addr0];
            r_rd_data1 <= mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

// ===== sv/pfcu_gate.sv =====
// Gate logic: new letters, write enables and sign for one item.
`timescale 1ns / 1ps

module pfcu_gate (
    input  pfcu_pkg::t_cmd               i_cmd,
    input  logic [pfcu_pkg::LTR_W-1:0]   i_letter1,
    input  logic [pfcu_pkg::LTR_W-1:0]   i_letter2,
    input  logic                         i_sign,
    output pfcu_pkg::t_upd               o_upd
);

    pfcu_pkg::t_pauli p;
    pfcu_pkg::t_upd   upd;

    always_comb begin
        upd      = '0;
        upd.new1 = i_letter1;
        upd.new2 = i_letter2;
        upd.sign = i_sign;
        p        = '0;
        unique case (i_cmd.action)
            pfcu_pkg::ACT_GATE: begin
                unique case (i_cmd.kind)
                    pfcu_pkg::GATE_H: begin
                        p = pfcu_pkg::f_had(i_letter1);
                        if (i_cmd.ok1) begin
                            upd.new1 = p.letter;
                            upd.we1  = 1'b1;
                            upd.sign = i_sign ^ p.neg;
                        end
                    end
                    pfcu_pkg::GATE_CX: begin
                        // Control Z picks up target Z, target X picks up control X.
                        // Sign flips for XZ and YY.
                        if (i_cmd.ok1 && i_cmd.ok2 && !i_cmd.same_q) begin
                            upd.new1 = {i_letter1[1] ^ i_letter2[1], i_letter1[0]};
                            upd.new2 = {i_letter2[1], i_letter2[0] ^ i_letter1[0]};
                            upd.we1  = 1'b1;
                            upd.we2  = 1'b1;
                            upd.sign = i_sign ^ (i_letter1[0] & i_letter2[1]
                                       & (i_letter1[1] ~^ i_letter2[0]));
                        end
                    end
                    pfcu_pkg::GATE_RZ: begin
                        p = pfcu_pkg::f_zrot(i_letter1, i_cmd.turns);
                        if (i_cmd.ok1) begin
                            upd.new1 = p.letter;
                            upd.we1  = 1'b1;
                            upd.sign = i_sign ^ p.neg;
                        end
                    end
                    pfcu_pkg::GATE_RX: begin
                        p = pfcu_pkg::f_xrot(i_letter1, i_cmd.turns);
                        if (i_cmd.ok1) begin
                            upd.new1 = p.letter;
                            upd.we1  = 1'b1;
                            upd.sign = i_sign ^ p.neg;
                        end
                    end
                    default: ;
                endcase
            end
            pfcu_pkg::ACT_WRITE: begin
                if (i_cmd.ok1) begin
                    upd.new1 = i_cmd.letter_in;
                    upd.we1  = 1'b1;
                end
            end
            pfcu_pkg::ACT_SIGN: begin
                upd.sign = i_cmd.sign_in;
            end
            pfcu_pkg::ACT_READ: ;
            default: ;
        endcase
        upd.res_letter = i_cmd.ok1 ? upd.new1 : pfcu_pkg::LTR_I;
    end

    assign o_upd = upd;

endmodule

// ===== sv/pauli_frame_clifford_update_top.sv =====
// Top level: Pauli frame register with Clifford gate conjugation.
`timescale 1ns / 1ps

// Holds a Pauli string (one 2-bit letter per qubit, 0 I, 1 X, 2 Z, 3 Y, plus a
// sign bit) and takes one item per clock while i_out_ready is high: push a
// Hadamard, CNOT, Z rotation or X rotation through the string, write a letter,
// set the sign, or just read. Every item returns one result: the letter at the
// first qubit after the step, the sign, and a diagonal flag (letter is I or Z).
// Qubits at or above NUM_QUBITS are ignored and read back as I. Throughput is
// one item per cycle while i_out_ready is high: the letter banks are read into
// a register at accept, then the gate logic writes back and loads the result
// register. The string is kept in two single-write banks whose XOR is the
// letter, so a CNOT can update two qubits in the same cycle; the last write of
// each bank is bypassed into the read data. After reset the block clears the
// banks to identity and holds o_in_ready low during that pass.
module pauli_frame_clifford_update_top #(
    parameter int unsigned NUM_QUBITS = pfcu_pkg::DEF_NUM_QUBITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [1:0]                     i_gate_kind,
    input  logic [pfcu_pkg::QUBIT_W-1:0]   i_first_qubit,
    input  logic [pfcu_pkg::QUBIT_W-1:0]   i_second_qubit,
    input  logic [pfcu_pkg::TURNS_W-1:0]   i_quarter_turns,
    input  logic [pfcu_pkg::LTR_W-1:0]     i_letter_in,
    input  logic                           i_sign_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pfcu_pkg::LTR_W-1:0]     o_letter_out,
    output logic                           o_negated,
    output logic                           o_is_diagonal
);

    localparam int unsigned AW = $clog2(NUM_QUBITS);
    localparam logic [10:0] NQ_W = 11'(NUM_QUBITS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_QUBITS - 1);

    // handshake
    logic in_accept;
    logic s1_fire;

    // clearing pass
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    // compute stage
    logic                          r_s1_valid;
    pfcu_pkg::t_action             r_s1_action;
    pfcu_pkg::t_gate               r_s1_kind;
    logic [pfcu_pkg::QUBIT_W-1:0]  r_s1_q1;
    logic [pfcu_pkg::QUBIT_W-1:0]  r_s1_q2;
    logic [pfcu_pkg::TURNS_W-1:0]  r_s1_turns;
    logic [pfcu_pkg::LTR_W-1:0]    r_s1_letter;
    logic                          r_s1_sign_in;
    logic [AW-1:0]                 s1_addr1;
    logic [AW-1:0]                 s1_addr2;
    pfcu_pkg::t_cmd                s1_cmd;
    pfcu_pkg::t_upd                upd;

    // sign
    logic r_sign;

    // banks and bypass
    logic [pfcu_pkg::LTR_W-1:0] rd_a1, rd_a2, rd_b1, rd_b2;
    logic [pfcu_pkg::LTR_W-1:0] fa1, fa2, fb1, fb2;
    logic [pfcu_pkg::LTR_W-1:0] letter1, letter2;
    logic                       r_fwd_a_en, r_fwd_b_en;
    logic [AW-1:0]              r_fwd_a_addr, r_fwd_b_addr;
    logic [pfcu_pkg::LTR_W-1:0] r_fwd_a_data, r_fwd_b_data;
    logic                       n_wa_en, n_wb_en;
    logic [AW-1:0]              n_wa_addr, n_wb_addr;
    logic [pfcu_pkg::LTR_W-1:0] n_wa_data, n_wb_data;

    // result register
    logic                       r_out_valid;
    logic [pfcu_pkg::LTR_W-1:0] r_out_letter;
    logic                       r_out_neg;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_fire);
    assign in_accept  = i_in_valid && o_in_ready;

    // Clearing pass after reset: one entry of each bank per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Compute stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action  <= pfcu_pkg::t_action'(i_action);
            r_s1_kind    <= pfcu_pkg::t_gate'(i_gate_kind);
            r_s1_q1      <= i_first_qubit;
            r_s1_q2      <= i_second_qubit;
            r_s1_turns   <= i_quarter_turns;
            r_s1_letter  <= i_letter_in;
            r_s1_sign_in <= i_sign_in;
        end
    end

    assign s1_addr1 = AW'(r_s1_q1);
    assign s1_addr2 = AW'(r_s1_q2);

    always_comb begin
        s1_cmd           = '0;
        s1_cmd.action    = r_s1_action;
        s1_cmd.kind      = r_s1_kind;
        s1_cmd.turns     = r_s1_turns;
        s1_cmd.letter_in = r_s1_letter;
        s1_cmd.sign_in   = r_s1_sign_in;
        s1_cmd.ok1       = (11'(r_s1_q1) < NQ_W);
        s1_cmd.ok2       = (11'(r_s1_q2) < NQ_W);
        s1_cmd.same_q    = (r_s1_q1 == r_s1_q2);
    end

    // Letter banks; the letter is bank A xor bank B.
    pfcu_bank #(.DEPTH(NUM_QUBITS)) u_bank_a (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr0 (AW'(i_first_qubit)),
        .i_rd_addr1 (AW'(i_second_qubit)),
        .o_rd_data0 (rd_a1),
        .o_rd_data1 (rd_a2),
        .i_wr_en    (n_wa_en),
        .i_wr_addr  (n_wa_addr),
        .i_wr_data  (n_wa_data)
    );

    pfcu_bank #(.DEPTH(NUM_QUBITS)) u_bank_b (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr0 (AW'(i_first_qubit)),
        .i_rd_addr1 (AW'(i_second_qubit)),
        .o_rd_data0 (rd_b1),
        .o_rd_data1 (rd_b2),
        .i_wr_en    (n_wb_en),
        .i_wr_addr  (n_wb_addr),
        .i_wr_data  (n_wb_data)
    );

    // Bypass the last write of each bank: its read may have been taken at
    // the same edge the write landed.
    assign fa1 = (r_fwd_a_en && r_fwd_a_addr == s1_addr1) ? r_fwd_a_data : rd_a1;
    assign fa2 = (r_fwd_a_en && r_fwd_a_addr == s1_addr2) ? r_fwd_a_data : rd_a2;
    assign fb1 = (r_fwd_b_en && r_fwd_b_addr == s1_addr1) ? r_fwd_b_data : rd_b1;
    assign fb2 = (r_fwd_b_en && r_fwd_b_addr == s1_addr2) ? r_fwd_b_data : rd_b2;

    assign letter1 = fa1 ^ fb1;
    assign letter2 = fa2 ^ fb2;

    pfcu_gate u_gate (
        .i_cmd     (s1_cmd),
        .i_letter1 (letter1),
        .i_letter2 (letter2),
        .i_sign    (r_sign),
        .o_upd     (upd)
    );

    // Bank A owns the first qubit's write, bank B the cnot target's.
    always_comb begin
        if (r_clearing) begin
            n_wa_en   = 1'b1;
            n_wa_addr = r_clr_idx;
            n_wa_data = pfcu_pkg::LTR_I;
            n_wb_en   = 1'b1;
            n_wb_addr = r_clr_idx;
            n_wb_data = pfcu_pkg::LTR_I;
        end else begin
            n_wa_en   = s1_fire && upd.we1;
            n_wa_addr = s1_addr1;
            n_wa_data = upd.new1 ^ fb1;
            n_wb_en   = s1_fire && upd.we2;
            n_wb_addr = s1_addr2;
            n_wb_data = upd.new2 ^ fa2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a_en <= 1'b0;
            r_fwd_b_en <= 1'b0;
        end else if (!r_clearing) begin
            if (n_wa_en) begin
                r_fwd_a_en <= 1'b1;
            end
            if (n_wb_en) begin
                r_fwd_b_en <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clearing && n_wa_en) begin
            r_fwd_a_addr <= n_wa_addr;
            r_fwd_a_data <= n_wa_data;
        end
        if (!r_clearing && n_wb_en) begin
            r_fwd_b_addr <= n_wb_addr;
            r_fwd_b_data <= n_wb_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign <= 1'b0;
        end else if (s1_fire) begin
            r_sign <= upd.sign;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_letter <= upd.res_letter;
            r_out_neg    <= upd.sign;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_letter_out  = r_out_letter;
    assign o_negated     = r_out_neg;
    assign o_is_diagonal = !r_out_letter[0];

    // No item enters while the banks are being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_in_ready)
        else $error("item accepted during clearing pass");

    // A waiting item moves into an empty result register.
    a_stage_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("compute stage stalled with empty result register");

    // A letter write in range reads back the written letter.
    a_write_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_action == pfcu_pkg::ACT_WRITE && s1_cmd.ok1)
        |=> (o_letter_out == $past(r_s1_letter)))
        else $error("written letter not returned");

    // A first qubit out of range reads as identity.
    a_out_of_range_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !s1_cmd.ok1) |=> (o_letter_out == pfcu_pkg::LTR_I))
        else $error("out of range qubit did not read as identity");

endmodule
